>>> rtl/core/ctqb_pkg.sv
// shared types and constants of the can transmit queue
`timescale 1ns / 1ps
`default_nettype none

package ctqb_pkg;

  // row of QueueDepth-1 cells (NumCells), so QueueDepth-1 frames fit
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned NumCells   = QueueDepth - 1;

  localparam int unsigned IdWidth   = 11;
  localparam int unsigned LenWidth  = 4;
  localparam int unsigned DataWidth = 64;

  localparam logic [LenWidth-1:0] MaxLen = LenWidth'(8);

  typedef enum logic {
    CMD_SEND       = 1'b0,
    CMD_MBOX_EMPTY = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [IdWidth-1:0]   cob_id;
    logic                 rtr;
    logic [LenWidth-1:0]  length;
    logic [DataWidth-1:0] payload;
  } frame_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

  // bytes at and above len are cleared, len already saturated to 8
  function automatic logic [DataWidth-1:0] data_mask(input logic [LenWidth-1:0] len);
    logic [DataWidth-1:0] mask;
    mask = '0;
    for (int b = 0; b < 8; b++) begin
      if (LenWidth'(b) < len) begin
        mask[b*8 +: 8] = 8'hff;
      end
    end
    return mask;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ctqb_if.sv
// request and response channel interfaces of the can transmit queue
`timescale 1ns / 1ps
`default_nettype none

interface ctqb_req_if;
  import ctqb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [IdWidth-1:0]   cob_id;
  logic                 rtr;
  logic [LenWidth-1:0]  length;
  logic [DataWidth-1:0] payload;
  logic                 mailbox_free;

  modport source (output valid, command, cob_id, rtr, length, payload, mailbox_free,
                  input ready);
  modport sink (input valid, command, cob_id, rtr, length, payload, mailbox_free,
                output ready);
endinterface

interface ctqb_rsp_if;
  import ctqb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 accepted;
  logic                 emit_valid;
  logic [IdWidth-1:0]   emit_cob_id;
  logic                 emit_rtr;
  logic [LenWidth-1:0]  emit_length;
  logic [DataWidth-1:0] emit_payload;
  logic                 tx_irq_enable;

  modport source (output valid, accepted, emit_valid, emit_cob_id, emit_rtr, emit_length,
                  emit_payload, tx_irq_enable, input ready);
  modport sink (input valid, accepted, emit_valid, emit_cob_id, emit_rtr, emit_length,
                emit_payload, tx_irq_enable, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ctqb_cell.sv
// one queue cell: holds a frame, loads at the tail, shifts toward the head on a pop
`timescale 1ns / 1ps
`default_nettype none

module ctqb_cell
  import ctqb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cell_ctrl_t ctrl_i,
  input  wire frame_t     new_frame_i,
  input  wire logic       prev_valid_i,
  input  wire logic       next_valid_i,
  input  wire frame_t     next_frame_i,
  output logic            valid_o,
  output frame_t          frame_o
);

  logic   valid_q, valid_d;
  frame_t frame_q, frame_d;
  logic   load;

  // first empty cell behind a full one takes the new frame
  assign load = ctrl_i.push && !valid_q && prev_valid_i;

  always_comb begin
    valid_d = valid_q;
    frame_d = frame_q;
    if (ctrl_i.pop) begin
      valid_d = next_valid_i;
      frame_d = next_frame_i;
    end else if (load) begin
      valid_d = 1'b1;
      frame_d = new_frame_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

  assign valid_o = valid_q;
  assign frame_o = frame_q;

endmodule

`default_nettype wire

>>> rtl/core/can_tx_queue_with_bypass.sv
// top level of the can transmit queue with direct bypass to the controller
// usage:
//   req_i carries one request per handshake: a send request (frame plus
//   mailbox_free) or a mailbox-empty event from the controller
//   rsp_o returns exactly one response per request: send status, the frame
//   handed to the controller (if any) and the transmit interrupt enable
//   the response is registered: a request accepted at one edge has its
//   response valid after that edge; one request per cycle is sustained while
//   the receiver takes responses, set by the single response register
//   the backlog is a row of QueueDepth-1 cells; a pop shifts every cell
//   one place toward the head, a push fills the first empty cell
//   when the queue is full a send request is dropped with accepted low
//   reset clears all cell valid bits, backlog mode and the response valid bit;
//   the block takes requests in the first cycle after reset
//   if the receiver stalls, the held response stays put and req_i.ready
//   drops until it is taken, so no response is lost or repeated
`timescale 1ns / 1ps
`default_nettype none

module can_tx_queue_with_bypass
  import ctqb_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ctqb_req_if.sink  req_i,
  ctqb_rsp_if.source rsp_o
);

  // handshake
  logic accept;
  logic out_valid_q;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  // incoming frame, length saturated and unused bytes cleared once here
  logic [LenWidth-1:0] len_sat;
  frame_t              in_frame;

  assign len_sat = (req_i.length > MaxLen) ? MaxLen : req_i.length;

  always_comb begin
    in_frame.cob_id  = req_i.cob_id;
    in_frame.rtr     = req_i.rtr;
    in_frame.length  = len_sat;
    in_frame.payload = req_i.payload & data_mask(len_sat);
  end

  // backlog mode keeps the mailbox-empty interrupt armed
  logic backlog_q, backlog_d;

  // cell row
  logic       cell_valid [NumCells];
  frame_t     cell_frame [NumCells];
  cell_ctrl_t ctrl;
  logic       is_send;
  logic       bypass;
  logic       full;
  logic       head_valid;

  assign is_send    = (req_i.command == CMD_SEND);
  assign bypass     = is_send && !backlog_q && req_i.mailbox_free;
  assign full       = cell_valid[NumCells-1];
  assign head_valid = cell_valid[0];

  assign ctrl.push = accept && is_send && !bypass && !full;
  assign ctrl.pop  = accept && !is_send && head_valid;

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    logic   prev_valid;
    logic   next_valid;
    frame_t next_frame;

    // head cell sees a full neighbour before it, tail cell an empty one after it
    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_mid_prev
      assign prev_valid = cell_valid[i-1];
    end

    if (i == NumCells - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_frame = '0;
    end else begin : g_mid_next
      assign next_valid = cell_valid[i+1];
      assign next_frame = cell_frame[i+1];
    end

    ctqb_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_frame_i  (in_frame),
      .prev_valid_i (prev_valid),
      .next_valid_i (next_valid),
      .next_frame_i (next_frame),
      .valid_o      (cell_valid[i]),
      .frame_o      (cell_frame[i])
    );
  end

  // response of this request
  logic   res_accepted;
  logic   res_emit;
  frame_t res_frame;

  always_comb begin
    backlog_d    = backlog_q;
    res_accepted = 1'b0;
    res_emit     = 1'b0;
    res_frame    = '0;
    if (is_send) begin
      if (bypass) begin
        res_accepted = 1'b1;
        res_emit     = 1'b1;
        res_frame    = in_frame;
      end else begin
        // frame queued, or dropped on a full queue; backlog on either way
        res_accepted = !full;
        backlog_d    = 1'b1;
      end
    end else begin
      if (head_valid) begin
        res_emit  = 1'b1;
        res_frame = cell_frame[0];
      end else begin
        // nothing left to send, interrupt off
        backlog_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backlog_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        backlog_q   <= backlog_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // response register, payload needs no reset
  logic   out_accepted_q;
  logic   out_emit_q;
  frame_t out_frame_q;
  logic   out_irq_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_accepted_q <= res_accepted;
      out_emit_q     <= res_emit;
      out_frame_q    <= res_frame;
      out_irq_q      <= backlog_d;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.accepted      = out_accepted_q;
  assign rsp_o.emit_valid    = out_emit_q;
  assign rsp_o.emit_cob_id   = out_frame_q.cob_id;
  assign rsp_o.emit_rtr      = out_frame_q.rtr;
  assign rsp_o.emit_length   = out_frame_q.length;
  assign rsp_o.emit_payload  = out_frame_q.payload;
  assign rsp_o.tx_irq_enable = out_irq_q;

endmodule

`default_nettype wire
